### sv/ftsp_pkg.sv
// ----------------------------------------------------------------------------
// ftsp_pkg: shared types and constants of the FLV tag stream parser
// Holds the phase type, the result record, field codes and the decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsp_pkg;

  // Width of the running file position; it wraps at this width.
  localparam int POSITION_BITS = 32;
  localparam int PCOUNT_W      = 24;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [PCOUNT_W-1:0]      pcount_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_PREV   = 3'd1,
    PH_TAGHDR = 3'd2,
    PH_BODY   = 3'd3
  } phase_t;

  // Record kinds.
  localparam logic [2:0] KIND_HDR_OK  = 3'd0;
  localparam logic [2:0] KIND_HDR_BAD = 3'd1;
  localparam logic [2:0] KIND_AUDIO   = 3'd2;
  localparam logic [2:0] KIND_VIDEO   = 3'd3;
  localparam logic [2:0] KIND_META    = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd5;

  // Tag types and codec.
  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_META   = 8'd18;
  localparam logic [3:0] CODEC_H263 = 4'd2;

  // File header signature and stream flag codes.
  localparam logic [23:0] FLV_SIGNATURE = 24'h464C56;
  localparam logic [7:0]  FLAGS_AV      = 8'd5;
  localparam logic [7:0]  FLAGS_A       = 8'd4;
  localparam logic [7:0]  FLAGS_V       = 8'd1;
  localparam logic [1:0]  MASK_AV       = 2'd3;
  localparam logic [1:0]  MASK_A        = 2'd2;
  localparam logic [1:0]  MASK_V        = 2'd1;

  // Byte positions inside each phase.
  localparam pcount_t HDR_SIG_END  = 24'd3;
  localparam pcount_t HDR_FLAGS    = 24'd4;
  localparam pcount_t HDR_LAST     = 24'd8;
  localparam pcount_t PREV_LAST    = 24'd3;
  localparam pcount_t TH_TYPE      = 24'd0;
  localparam pcount_t TH_LEN_LAST  = 24'd3;
  localparam pcount_t TH_TS_LAST   = 24'd6;
  localparam pcount_t TH_LAST      = 24'd10;
  localparam pcount_t BODY_FIRST   = 24'd0;
  localparam pcount_t BODY_SIZE_HI = 24'd4;
  localparam pcount_t BODY_SIZE_LO = 24'd5;

  // H.263 picture size codes.
  localparam logic [2:0] PSIZE_CUSTOM0 = 3'd0;
  localparam logic [2:0] PSIZE_CUSTOM1 = 3'd1;
  localparam logic [2:0] PSIZE_CIF     = 3'd2;
  localparam logic [2:0] PSIZE_QCIF    = 3'd3;
  localparam logic [2:0] PSIZE_SQCIF   = 3'd4;
  localparam logic [2:0] PSIZE_QVGA    = 3'd5;
  localparam logic [2:0] PSIZE_QQVGA   = 3'd6;

  // Result queue.
  localparam int QUEUE_DEPTH = 3;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [1:0]  stream_mask;
    logic [23:0] payload_size;
    logic [23:0] time_stamp;
    logic [31:0] payload_offset;
    logic [3:0]  upper_format;
    logic [3:0]  video_codec;
    logic [15:0] sample_rate_hz;
    logic [1:0]  sample_bytes;
    logic        is_stereo;
    logic [8:0]  picture_width;
    logic [8:0]  picture_height;
  } rec_t;

  function automatic logic [15:0] audio_rate(input logic [1:0] code);
    logic [15:0] r;
    case (code)
      2'd0:    r = 16'd5500;
      2'd1:    r = 16'd11000;
      2'd2:    r = 16'd22050;
      default: r = 16'd44100;
    endcase
    return r;
  endfunction

  // Builds the record that closes a tag.
  function automatic rec_t tag_record(input logic [7:0]  tag_type,
                                      input logic [23:0] body_len,
                                      input logic [23:0] stamp,
                                      input logic [1:0]  flags,
                                      input logic [7:0]  fbb,
                                      input logic [15:0] sbb,
                                      input logic        vit,
                                      input pos_t        last_pos);
    rec_t       r;
    logic [2:0] code;
    pos_t       off;
    r = '0;
    code = {sbb[9:8], sbb[7]};
    r.stream_mask  = flags;
    r.payload_size = (body_len != 24'd0) ? body_len - 24'd1 : 24'd0;
    r.time_stamp   = stamp;
    off = last_pos - pos_t'(body_len) + pos_t'(2);
    r.payload_offset = 32'(off);
    if (tag_type == TAG_AUDIO) begin
      r.record_kind    = KIND_AUDIO;
      r.upper_format   = fbb[7:4];
      r.sample_rate_hz = audio_rate(fbb[3:2]);
      r.sample_bytes   = fbb[1] ? 2'd2 : 2'd1;
      r.is_stereo      = fbb[0];
    end else if (tag_type == TAG_VIDEO) begin
      r.record_kind  = KIND_VIDEO;
      r.upper_format = fbb[7:4];
      r.video_codec  = fbb[3:0];
      if (!vit) begin
        r.picture_width  = 9'd320;
        r.picture_height = 9'd240;
        if (fbb[3:0] == CODEC_H263) begin
          case (code)
            PSIZE_CUSTOM0, PSIZE_CUSTOM1: begin
              r.picture_width  = 9'd0;
              r.picture_height = 9'd0;
            end
            PSIZE_CIF: begin
              r.picture_width  = 9'd352;
              r.picture_height = 9'd288;
            end
            PSIZE_QCIF: begin
              r.picture_width  = 9'd176;
              r.picture_height = 9'd144;
            end
            PSIZE_SQCIF: begin
              r.picture_width  = 9'd128;
              r.picture_height = 9'd96;
            end
            PSIZE_QVGA: begin
              r.picture_width  = 9'd320;
              r.picture_height = 9'd240;
            end
            PSIZE_QQVGA: begin
              r.picture_width  = 9'd160;
              r.picture_height = 9'd120;
            end
            default: begin
            end
          endcase
        end
      end
    end else if (tag_type == TAG_META) begin
      r.record_kind = KIND_META;
    end else begin
      r.record_kind = KIND_UNKNOWN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ftsp_if.sv
// ----------------------------------------------------------------------------
// ftsp_if: channel interfaces of the FLV tag stream parser
// A byte channel into the parser and a record channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ftsp_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [1:0]  stream_mask;
  logic [23:0] payload_size;
  logic [23:0] time_stamp;
  logic [31:0] payload_offset;
  logic [3:0]  upper_format;
  logic [3:0]  video_codec;
  logic [15:0] sample_rate_hz;
  logic [1:0]  sample_bytes;
  logic        is_stereo;
  logic [8:0]  picture_width;
  logic [8:0]  picture_height;

  modport source (output valid, output record_kind, output stream_mask,
                  output payload_size, output time_stamp, output payload_offset,
                  output upper_format, output video_codec, output sample_rate_hz,
                  output sample_bytes, output is_stereo, output picture_width,
                  output picture_height, input ready);
  modport sink   (input valid, input record_kind, input stream_mask,
                  input payload_size, input time_stamp, input payload_offset,
                  input upper_format, input video_codec, input sample_rate_hz,
                  input sample_bytes, input is_stereo, input picture_width,
                  input picture_height, output ready);
endinterface

`default_nettype wire

### sv/flv_tag_stream_parser_core.sv
// ----------------------------------------------------------------------------
// flv_tag_stream_parser_core: FLV container tag parser
// Checks the file header, walks the tag stream byte by byte and reports
// one record per header and per finished tag.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Request carries                    Handshake
//   bytes     in   data_byte, next byte of the file   valid/ready
//   records   out  one record per header or tag       valid/ready
//
// One byte per clock is sustained while the queue has room. A request is
// registered, decoded against the parser state in the next cycle and any
// record is written to a three-entry result queue that feeds the record channel.
// Input ready drops only while the queue and the input register together hold
// three records' worth; output stalls therefore do not stall the input at once.
// Synchronous reset returns to the file header phase and empties the queue.
// After a bad signature or an unknown tag type every byte is consumed silently.
//
`default_nettype none

module flv_tag_stream_parser_core (
  input  wire logic      clk,
  input  wire logic      rst,
  ftsp_byte_if.sink      bytes,
  ftsp_rec_if.source     records
);
  import ftsp_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state.
  phase_t      phase, phase_next;
  pcount_t     phase_count, phase_count_next;
  pos_t        file_position, file_position_next;
  logic [7:0]  tag_type, tag_type_next;
  logic [23:0] body_length, body_length_next;
  logic [23:0] stamp_value, stamp_value_next;
  logic [7:0]  first_body_byte, first_body_byte_next;
  logic [15:0] size_bits_bytes, size_bits_bytes_next;
  logic [1:0]  flags_seen, flags_seen_next;
  logic        video_info_taken, video_info_taken_next;
  logic        halted, halted_next;

  logic              emit_tag;
  logic              push;
  rec_t              push_rec;
  rec_t              head;
  logic              pop;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   occupancy;

  assign occupancy   = {1'b0, q_count} + {{QCNT_W{1'b0}}, in_valid_q};
  assign bytes.ready = (occupancy < (QCNT_W + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= bytes.valid && bytes.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte_q <= bytes.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      phase_count      <= '0;
      file_position    <= '0;
      tag_type         <= '0;
      body_length      <= '0;
      stamp_value      <= '0;
      first_body_byte  <= '0;
      size_bits_bytes  <= '0;
      flags_seen       <= '0;
      video_info_taken <= 1'b0;
      halted           <= 1'b0;
    end else begin
      phase            <= phase_next;
      phase_count      <= phase_count_next;
      file_position    <= file_position_next;
      tag_type         <= tag_type_next;
      body_length      <= body_length_next;
      stamp_value      <= stamp_value_next;
      first_body_byte  <= first_body_byte_next;
      size_bits_bytes  <= size_bits_bytes_next;
      flags_seen       <= flags_seen_next;
      video_info_taken <= video_info_taken_next;
      halted           <= halted_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    phase_count_next      = phase_count;
    file_position_next    = file_position;
    tag_type_next         = tag_type;
    body_length_next      = body_length;
    stamp_value_next      = stamp_value;
    first_body_byte_next  = first_body_byte;
    size_bits_bytes_next  = size_bits_bytes;
    flags_seen_next       = flags_seen;
    video_info_taken_next = video_info_taken;
    halted_next           = halted;
    emit_tag              = 1'b0;
    push                  = 1'b0;
    push_rec              = '0;

    if (in_valid_q && !halted) begin
      file_position_next = file_position + pos_t'(1);
      case (phase)
        PH_HEADER: begin
          // The signature is collected in the timestamp register.
          if (phase_count < HDR_SIG_END) begin
            stamp_value_next = {stamp_value[15:0], in_byte_q};
          end else if (phase_count == HDR_FLAGS) begin
            if (in_byte_q == FLAGS_AV) begin
              flags_seen_next = MASK_AV;
            end else if (in_byte_q == FLAGS_A) begin
              flags_seen_next = MASK_A;
            end else if (in_byte_q == FLAGS_V) begin
              flags_seen_next = MASK_V;
            end else begin
              flags_seen_next = 2'd0;
            end
          end
          if (phase_count >= HDR_LAST) begin
            push = 1'b1;
            if (stamp_value_next != FLV_SIGNATURE) begin
              flags_seen_next      = 2'd0;
              push_rec.record_kind = KIND_HDR_BAD;
              halted_next          = 1'b1;
            end else begin
              push_rec.record_kind = KIND_HDR_OK;
              push_rec.stream_mask = flags_seen_next;
            end
            stamp_value_next = '0;
            phase_next       = PH_PREV;
            phase_count_next = '0;
          end else begin
            phase_count_next = phase_count + pcount_t'(1);
          end
        end
        PH_PREV: begin
          if (phase_count >= PREV_LAST) begin
            phase_next       = PH_TAGHDR;
            phase_count_next = '0;
          end else begin
            phase_count_next = phase_count + pcount_t'(1);
          end
        end
        PH_TAGHDR: begin
          if (phase_count == TH_TYPE) begin
            tag_type_next = in_byte_q;
          end else if (phase_count <= TH_LEN_LAST) begin
            body_length_next = {body_length[15:0], in_byte_q};
          end else if (phase_count <= TH_TS_LAST) begin
            stamp_value_next = {stamp_value[15:0], in_byte_q};
          end
          if (phase_count >= TH_LAST) begin
            first_body_byte_next = '0;
            size_bits_bytes_next = '0;
            if (tag_type_next != TAG_AUDIO && tag_type_next != TAG_VIDEO &&
                tag_type_next != TAG_META) begin
              emit_tag    = 1'b1;
              halted_next = 1'b1;
            end else if (body_length_next == 24'd0) begin
              // An empty body closes the tag right here.
              emit_tag   = 1'b1;
              phase_next = PH_PREV;
            end else begin
              phase_next = PH_BODY;
            end
            phase_count_next = '0;
          end else begin
            phase_count_next = phase_count + pcount_t'(1);
          end
        end
        PH_BODY: begin
          if (phase_count == BODY_FIRST) begin
            first_body_byte_next = in_byte_q;
          end else if (phase_count == BODY_SIZE_HI) begin
            size_bits_bytes_next = {in_byte_q, size_bits_bytes[7:0]};
          end else if (phase_count == BODY_SIZE_LO) begin
            size_bits_bytes_next = {size_bits_bytes[15:8], in_byte_q};
          end
          if (({1'b0, phase_count} + 25'd1) >= {1'b0, body_length}) begin
            emit_tag         = 1'b1;
            phase_next       = PH_PREV;
            phase_count_next = '0;
          end else begin
            phase_count_next = phase_count + pcount_t'(1);
          end
        end
        default: begin
          phase_next       = PH_HEADER;
          phase_count_next = '0;
        end
      endcase

      if (emit_tag) begin
        push     = 1'b1;
        push_rec = tag_record(tag_type_next, body_length_next, stamp_value_next,
                              flags_seen_next, first_body_byte_next,
                              size_bits_bytes_next, video_info_taken, file_position);
        if (tag_type_next == TAG_VIDEO) begin
          video_info_taken_next = 1'b1;
        end
      end
    end
  end

  assign pop = records.valid && records.ready;

  ftsp_rec_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  assign records.valid          = (q_count != '0);
  assign records.record_kind    = head.record_kind;
  assign records.stream_mask    = head.stream_mask;
  assign records.payload_size   = head.payload_size;
  assign records.time_stamp     = head.time_stamp;
  assign records.payload_offset = head.payload_offset;
  assign records.upper_format   = head.upper_format;
  assign records.video_codec    = head.video_codec;
  assign records.sample_rate_hz = head.sample_rate_hz;
  assign records.sample_bytes   = head.sample_bytes;
  assign records.is_stereo      = head.is_stereo;
  assign records.picture_width  = head.picture_width;
  assign records.picture_height = head.picture_height;

`ifndef NO_ASSERTIONS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
    else $error("record pushed into a full result queue");

  a_push_needs_byte: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid_q && !halted))
    else $error("record produced without a live input byte");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("parser left the halted state without reset");

  a_header_kind: assert property (@(posedge clk) disable iff (rst)
    (push && phase == PH_HEADER) |->
      (push_rec.record_kind == KIND_HDR_OK || push_rec.record_kind == KIND_HDR_BAD))
    else $error("header phase produced a tag record");
`endif

endmodule

`default_nettype wire

### sv/ftsp_rec_fifo.sv
// ----------------------------------------------------------------------------
// ftsp_rec_fifo: small result queue
// Holds finished records until the downstream side takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsp_rec_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ftsp_pkg::rec_t        push_rec,
  input  wire logic                  pop,
  output ftsp_pkg::rec_t             head,
  output logic [ftsp_pkg::QCNT_W-1:0] count
);
  import ftsp_pkg::*;

  rec_t              entries [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;

  function automatic logic [QIDX_W-1:0] ptr_inc(input logic [QIDX_W-1:0] p);
    return (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + QIDX_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign head = entries[rd_ptr];

endmodule

`default_nettype wire

### tb/flv_tag_stream_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_stream_parser_core_tb: self-checking bench for the FLV tag parser
// Streams a well-formed FLV file with random tag content and random gaps on
// both channels. A mirror of the parser state predicts every header and tag
// record, and each record that leaves the block is checked field by field.
// The file ends in an unknown tag type followed by bytes that must be ignored.
// ----------------------------------------------------------------------------

module flv_tag_stream_parser_core_tb;
  import ftsp_pkg::*;

  logic clk;
  logic rst;

  ftsp_byte_if byte_ch ();
  ftsp_rec_if  rec_ch ();

  flv_tag_stream_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .records (rec_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mirror of the parser state.
  phase_t      mp_phase      = PH_HEADER;
  pcount_t     mp_count      = '0;
  pos_t        mp_pos        = '0;
  logic [7:0]  mp_type       = '0;
  logic [23:0] mp_len        = '0;
  logic [23:0] mp_stamp      = '0;
  logic [7:0]  mp_first      = '0;
  logic [15:0] mp_size_bytes = '0;
  logic [1:0]  mp_flags      = '0;
  logic        mp_video_seen = 1'b0;
  logic        mp_halted     = 1'b0;

  rec_t        pending_records[$];

  int unsigned bytes_sent;
  int unsigned records_predicted;
  int unsigned records_checked;
  int unsigned mismatches;
  int unsigned kind_count[8];
  bit          calm_input;
  bit          calm_output;

  function automatic string rec_text(input rec_t r);
    return {$sformatf("kind=%0d mask=%0d size=%0d ts=%0d off=%0d fmt=%0d codec=%0d",
                      r.record_kind, r.stream_mask, r.payload_size, r.time_stamp,
                      r.payload_offset, r.upper_format, r.video_codec),
            $sformatf(" rate=%0d bytes=%0d stereo=%0d pic=%0dx%0d",
                      r.sample_rate_hz, r.sample_bytes, r.is_stereo,
                      r.picture_width, r.picture_height)};
  endfunction

  task automatic push_record(input rec_t r);
    pending_records.insert(pending_records.size(), r);
    records_predicted++;
    kind_count[r.record_kind]++;
  endtask

  // Builds the record that closes the current tag; last_pos is the offset of
  // the byte that ends it.
  task automatic predict_tag_record(input pos_t last_pos);
    rec_t       r;
    logic [2:0] psize;
    pos_t       off;
    r = '0;
    r.stream_mask  = mp_flags;
    r.payload_size = (mp_len == 24'd0) ? 24'd0 : mp_len - 24'd1;
    r.time_stamp   = mp_stamp;
    off = last_pos - pos_t'(mp_len) + pos_t'(2);
    r.payload_offset = off[31:0];
    case (mp_type)
      TAG_AUDIO: begin
        r.record_kind  = KIND_AUDIO;
        r.upper_format = mp_first[7:4];
        case (mp_first[3:2])
          2'd0:    r.sample_rate_hz = 16'd5500;
          2'd1:    r.sample_rate_hz = 16'd11000;
          2'd2:    r.sample_rate_hz = 16'd22050;
          default: r.sample_rate_hz = 16'd44100;
        endcase
        r.sample_bytes = mp_first[1] ? 2'd2 : 2'd1;
        r.is_stereo    = mp_first[0];
      end
      TAG_VIDEO: begin
        r.record_kind  = KIND_VIDEO;
        r.upper_format = mp_first[7:4];
        r.video_codec  = mp_first[3:0];
        if (!mp_video_seen) begin
          {r.picture_width, r.picture_height} = {9'd320, 9'd240};
          if (mp_first[3:0] == CODEC_H263) begin
            psize = {mp_size_bytes[9:8], mp_size_bytes[7]};
            case (psize)
              PSIZE_CUSTOM0: {r.picture_width, r.picture_height} = '0;
              PSIZE_CUSTOM1: {r.picture_width, r.picture_height} = '0;
              PSIZE_CIF:     {r.picture_width, r.picture_height} = {9'd352, 9'd288};
              PSIZE_QCIF:    {r.picture_width, r.picture_height} = {9'd176, 9'd144};
              PSIZE_SQCIF:   {r.picture_width, r.picture_height} = {9'd128, 9'd96};
              PSIZE_QQVGA:   {r.picture_width, r.picture_height} = {9'd160, 9'd120};
              default: begin
              end
            endcase
          end
          mp_video_seen = 1'b1;
        end
      end
      TAG_META: begin
        r.record_kind = KIND_META;
      end
      default: begin
        r.record_kind = KIND_UNKNOWN;
      end
    endcase
    push_record(r);
  endtask

  // Advances the mirror by one accepted byte and queues any record it closes.
  task automatic track_file_byte(input logic [7:0] b);
    pos_t here;
    rec_t r;
    if (mp_halted) return;
    here   = mp_pos;
    mp_pos = mp_pos + pos_t'(1);
    case (mp_phase)
      PH_HEADER: begin
        if (mp_count < HDR_SIG_END) begin
          mp_stamp = {mp_stamp[15:0], b};
        end else if (mp_count == HDR_FLAGS) begin
          mp_flags = (b == FLAGS_AV) ? MASK_AV :
                     (b == FLAGS_A)  ? MASK_A  :
                     (b == FLAGS_V)  ? MASK_V  : 2'b00;
        end
        if (mp_count >= HDR_LAST) begin
          r = '0;
          if (mp_stamp != FLV_SIGNATURE) begin
            mp_flags      = 2'b00;
            r.record_kind = KIND_HDR_BAD;
            mp_halted     = 1'b1;
          end else begin
            r.record_kind = KIND_HDR_OK;
            r.stream_mask = mp_flags;
          end
          push_record(r);
          mp_stamp = '0;
          mp_phase = PH_PREV;
          mp_count = '0;
        end else begin
          mp_count++;
        end
      end
      PH_PREV: begin
        if (mp_count >= PREV_LAST) begin
          mp_phase = PH_TAGHDR;
          mp_count = '0;
        end else begin
          mp_count++;
        end
      end
      PH_TAGHDR: begin
        if (mp_count == TH_TYPE) begin
          mp_type = b;
        end else if (mp_count <= TH_LEN_LAST) begin
          mp_len = {mp_len[15:0], b};
        end else if (mp_count <= TH_TS_LAST) begin
          mp_stamp = {mp_stamp[15:0], b};
        end
        if (mp_count >= TH_LAST) begin
          mp_first      = '0;
          mp_size_bytes = '0;
          if (mp_type != TAG_AUDIO && mp_type != TAG_VIDEO && mp_type != TAG_META) begin
            predict_tag_record(here);
            mp_halted = 1'b1;
          end else if (mp_len == 24'd0) begin
            predict_tag_record(here);
            mp_phase = PH_PREV;
          end else begin
            mp_phase = PH_BODY;
          end
          mp_count = '0;
        end else begin
          mp_count++;
        end
      end
      default: begin
        if (mp_count == BODY_FIRST) begin
          mp_first = b;
        end else if (mp_count == BODY_SIZE_HI) begin
          mp_size_bytes = {b, mp_size_bytes[7:0]};
        end else if (mp_count == BODY_SIZE_LO) begin
          mp_size_bytes = {mp_size_bytes[15:8], b};
        end
        if ({1'b0, mp_count} + 25'd1 >= {1'b0, mp_len}) begin
          predict_tag_record(here);
          mp_phase = PH_PREV;
          mp_count = '0;
        end else begin
          mp_count++;
        end
      end
    endcase
  endtask

  // Each request waits out its own random gap (none while calm_input is set), then holds valid until taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm_input ? 0 : $urandom_range(5, 0);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    track_file_byte(b);
    bytes_sent++;
  endtask

  // Sends a previous-tag-size field, a tag header and a body. With set_size
  // the body bytes that carry the H.263 picture size code are shaped to code.
  task automatic send_tag(input logic [7:0] tag_code, input logic [23:0] len,
                          input logic [23:0] stamp, input logic [7:0] first,
                          input bit set_size, input logic [2:0] code);
    logic [7:0] b;
    calm_input = ($urandom_range(3, 0) == 0);
    repeat (4) send_byte(8'($urandom));
    send_byte(tag_code);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(stamp[23:16]);
    send_byte(stamp[15:8]);
    send_byte(stamp[7:0]);
    repeat (4) send_byte(8'($urandom));
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        b = first;
      end else if (set_size && i == 4) begin
        b[1:0] = code[2:1];
      end else if (set_size && i == 5) begin
        b[7] = code[0];
      end
      send_byte(b);
    end
  endtask

  task automatic test_file_header();
    logic [7:0] flags;
    case ($urandom_range(3, 0))
      0:       flags = FLAGS_AV;
      1:       flags = FLAGS_A;
      2:       flags = FLAGS_V;
      default: flags = 8'($urandom);
    endcase
    send_byte(FLV_SIGNATURE[23:16]);
    send_byte(FLV_SIGNATURE[15:8]);
    send_byte(FLV_SIGNATURE[7:0]);
    send_byte(8'($urandom));
    send_byte(flags);
    repeat (4) send_byte(8'($urandom));
  endtask

  task automatic test_directed_tags();
    logic [3:0]  codec;
    logic [23:0] vlen;
    // The first video tag alone reports a picture size. Bodies shorter than
    // five bytes leave the size bits at zero; a five-byte body sets only the upper size byte.
    codec = ($urandom_range(3, 0) == 0) ? 4'($urandom) : CODEC_H263;
    vlen  = 24'($urandom_range(8, 0));
    send_tag(TAG_VIDEO, vlen, 24'h000000, {4'($urandom), codec}, 1'b1, 3'($urandom));
    send_tag(TAG_AUDIO, 24'd1, 24'hFFFFFF, 8'hFF, 1'b0, 3'd0);
    send_tag(TAG_AUDIO, 24'd2, 24'h000001, 8'h00, 1'b0, 3'd0);
    send_tag(TAG_AUDIO, 24'd0, 24'h800000, 8'h00, 1'b0, 3'd0);
    send_tag(TAG_META, 24'd0, 24'h7FFFFF, 8'h00, 1'b0, 3'd0);
    send_tag(TAG_META, 24'd3, 24'h123456, 8'hA5, 1'b0, 3'd0);
    send_tag(TAG_VIDEO, 24'd1, 24'hFFFFFE, 8'hF2, 1'b0, 3'd0);
    send_tag(TAG_VIDEO, 24'd0, 24'h000002, 8'h00, 1'b0, 3'd0);
  endtask

  task automatic test_random_tags();
    int unsigned byte_mark;
    int unsigned pick;
    logic [7:0]  tag_code;
    logic [23:0] len;
    byte_mark = bytes_sent;
    while (bytes_sent - byte_mark < 800) begin
      case ($urandom_range(4, 0))
        0, 1:    tag_code = TAG_AUDIO;
        2, 3:    tag_code = TAG_VIDEO;
        default: tag_code = TAG_META;
      endcase
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        len = 24'd0;
      end else if (pick < 97) begin
        len = 24'($urandom_range(24, 1));
      end else begin
        len = 24'($urandom_range(600, 200));
      end
      send_tag(tag_code, len, 24'($urandom), 8'($urandom), 1'($urandom_range(1, 0)),
               3'($urandom));
    end
  endtask

  task automatic test_unknown_tag();
    logic [7:0] tag_code;
    do tag_code = 8'($urandom);
    while (tag_code == TAG_AUDIO || tag_code == TAG_VIDEO || tag_code == TAG_META);
    send_tag(tag_code, 24'($urandom_range(20, 0)), 24'($urandom), 8'($urandom), 1'b0, 3'd0);
    // The parser is halted now, so none of these may produce a record.
    repeat (30) send_byte(8'($urandom));
  endtask

  task automatic report_mismatch(input string what, input string detail);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $time, what);
      $display("  %s", detail);
    end
  endtask

  task automatic check_record(input rec_t got);
    rec_t want;
    if (pending_records.size() == 0) begin
      report_mismatch("record arrived with none expected", rec_text(got));
      return;
    end
    want = pending_records.pop_front();
    records_checked++;
    if (got !== want) begin
      report_mismatch("record mismatch",
                      {"expected ", rec_text(want), "\n  actual   ", rec_text(got)});
    end
  endtask

  initial begin : record_sink
    int unsigned stall;
    rec_t        got;
    rec_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(15, 0) == 0) calm_output = !calm_output;
      stall = calm_output ? 0 : $urandom_range(5, 0);
      if (stall > 0) begin
        rec_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rec_ch.ready <= 1'b1;
      do @(posedge clk); while (rec_ch.valid !== 1'b1);
      got.record_kind    = rec_ch.record_kind;
      got.stream_mask    = rec_ch.stream_mask;
      got.payload_size   = rec_ch.payload_size;
      got.time_stamp     = rec_ch.time_stamp;
      got.payload_offset = rec_ch.payload_offset;
      got.upper_format   = rec_ch.upper_format;
      got.video_codec    = rec_ch.video_codec;
      got.sample_rate_hz = rec_ch.sample_rate_hz;
      got.sample_bytes   = rec_ch.sample_bytes;
      got.is_stereo      = rec_ch.is_stereo;
      got.picture_width  = rec_ch.picture_width;
      got.picture_height = rec_ch.picture_height;
      check_record(got);
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d records still expected.", pending_records.size());
    $display("flv_tag_stream_parser_core_tb: FAIL");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_file_header();
    test_directed_tags();
    test_random_tags();
    test_unknown_tag();
    byte_ch.valid <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d file bytes; checked %0d records (%0d audio, %0d video, %0d meta,",
             bytes_sent, records_checked, kind_count[KIND_AUDIO], kind_count[KIND_VIDEO],
             kind_count[KIND_META]);
    $display("%0d unknown). Header records: %0d, mismatches: %0d.", kind_count[KIND_UNKNOWN],
             kind_count[KIND_HDR_OK] + kind_count[KIND_HDR_BAD], mismatches);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("flv_tag_stream_parser_core_tb: PASS");
    end else begin
      $display("flv_tag_stream_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/ftsp_pkg.sv
sv/ftsp_if.sv
sv/ftsp_rec_fifo.sv
sv/flv_tag_stream_parser_core.sv
tb/flv_tag_stream_parser_core_tb.sv
